FILE: src/sgd_momentum_weight_update_top_assert.svh
// Assertion macros shared by the checker of the weight update block.
`ifndef SGD_MOMENTUM_WEIGHT_UPDATE_TOP_ASSERT_SVH
`define SGD_MOMENTUM_WEIGHT_UPDATE_TOP_ASSERT_SVH

// Checks that cond in one cycle implies nxt in the next, outside reset.
`define SGDM_ASSERT_NEXT(label, cond, nxt) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (nxt)) \
      else $error("sgdm check failed");

// The same check, also active while reset is held.
`define SGDM_ASSERT_NEXT_RST(label, cond, nxt) \
   label: assert property (@(posedge clock) (cond) |=> (nxt)) \
      else $error("sgdm check failed");

`endif

FILE: src/sgdm_pkg.sv
// Shared types, codes and constants of the momentum weight update block.
`timescale 1ns / 1ps
package sgdm_pkg;

   localparam int NUM_WEIGHTS_DEFAULT = 1024;

   localparam logic [1:0] OP_LOAD   = 2'd0;
   localparam logic [1:0] OP_GRAD   = 2'd1;
   localparam logic [1:0] OP_REPORT = 2'd2;

   localparam logic [1:0] REG_INITIAL_RATE    = 2'd0;
   localparam logic [1:0] REG_DECREASE_FACTOR = 2'd1;
   localparam logic [1:0] REG_MOMENTUM_GAIN   = 2'd2;

   localparam logic [23:0] INITIAL_RATE_RESET    = 24'd655;
   localparam logic [15:0] DECREASE_FACTOR_RESET = 16'd32768;
   localparam logic [15:0] MOMENTUM_GAIN_RESET   = 16'd0;
   localparam logic [23:0] RATE_MAX              = 24'hFFFFFF;

   // Multiplying by RECIP_TEN and dropping RECIP_SHIFT bits divides by ten
   // exactly for every dividend below 2^17.
   localparam logic [18:0] RECIP_TEN   = 19'd419431;
   localparam int          RECIP_SHIFT = 22;

   typedef struct packed {
      logic [1:0]         opcode;
      logic [9:0]         index;
      logic signed [31:0] value;
   } req_payload_type;

   typedef struct packed {
      logic signed [31:0] weight;
      logic [23:0]        rate;
      logic               saturated;
   } rsp_payload_type;

   typedef struct packed {
      logic rd_en;
      logic wr_weight;
      logic wr_update;
   } mem_ctl_type;

endpackage

FILE: src/sgdm_csr.sv
// Configuration registers and the derived rate growth scale.
`timescale 1ns / 1ps
module sgdm_csr import sgdm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   output logic [15:0] momentum_gain,
   output logic [16:0] decrease_factor_x,
   output logic [16:0] growth_scale
);

   logic [23:0] initial_rate_ff;
   logic [15:0] decrease_factor_ff;
   logic [15:0] momentum_gain_ff;
   logic [16:0] scale_ff;
   logic [16:0] scale_in;
   logic [16:0] grow_num;
   logic [35:0] grow_prod;
   logic        wr_en;

   assign csr_pready = 1'b1;
   assign wr_en = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         initial_rate_ff    <= INITIAL_RATE_RESET;
         decrease_factor_ff <= DECREASE_FACTOR_RESET;
         momentum_gain_ff   <= MOMENTUM_GAIN_RESET;
      end else if (wr_en) begin
         case (csr_paddr[3:2])
            REG_INITIAL_RATE:    initial_rate_ff    <= csr_pwdata[23:0];
            REG_DECREASE_FACTOR: decrease_factor_ff <= csr_pwdata[15:0];
            REG_MOMENTUM_GAIN:   momentum_gain_ff   <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         REG_INITIAL_RATE:    csr_prdata = {8'd0, initial_rate_ff};
         REG_DECREASE_FACTOR: csr_prdata = {16'd0, decrease_factor_ff};
         REG_MOMENTUM_GAIN:   csr_prdata = {16'd0, momentum_gain_ff};
         default:             csr_prdata = 32'd0;
      endcase
   end

   // Growth scale is one plus (one minus factor) over ten, rounded half up.
   always_comb begin
      grow_num  = 17'd65541 - {1'b0, decrease_factor_ff};
      grow_prod = 36'(grow_num) * 36'(RECIP_TEN);
      scale_in  = 17'h10000 + 17'(grow_prod[35:RECIP_SHIFT]);
   end

   always_ff @(posedge clock) begin
      scale_ff <= scale_in;
   end

   assign momentum_gain     = momentum_gain_ff;
   assign decrease_factor_x = {1'b0, decrease_factor_ff};
   assign growth_scale      = scale_ff;

endmodule

FILE: src/sgdm_mem.sv
// Weight and update memories with the update clearing pass after reset.
`timescale 1ns / 1ps
module sgdm_mem import sgdm_pkg::*; #(
   parameter int NUM_WEIGHTS = NUM_WEIGHTS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  mem_ctl_type                    ctl,
   input  logic [$clog2(NUM_WEIGHTS)-1:0] rd_addr,
   input  logic [$clog2(NUM_WEIGHTS)-1:0] wr_addr,
   input  logic signed [31:0]             wr_weight_data,
   input  logic signed [31:0]             wr_update_data,
   output logic signed [31:0]             rd_weight,
   output logic signed [31:0]             rd_update,
   output logic                           ready
);

   localparam int AW = $clog2(NUM_WEIGHTS);

   logic signed [31:0] weight_mem [NUM_WEIGHTS];
   logic signed [31:0] update_mem [NUM_WEIGHTS];
   logic signed [31:0] rd_weight_ff;
   logic signed [31:0] rd_update_ff;
   logic [AW-1:0]      clr_addr_ff;
   logic               clr_busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
         clr_busy_ff <= 1'b1;
      end else if (clr_busy_ff) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
         if (clr_addr_ff == AW'(NUM_WEIGHTS - 1)) begin
            clr_busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.wr_weight) begin
         weight_mem[wr_addr] <= wr_weight_data;
      end
      if (ctl.rd_en) begin
         rd_weight_ff <= weight_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         update_mem[clr_addr_ff] <= 32'sd0;
      end else if (ctl.wr_update) begin
         update_mem[wr_addr] <= wr_update_data;
      end
      if (ctl.rd_en) begin
         rd_update_ff <= update_mem[rd_addr];
      end
   end

   assign rd_weight = rd_weight_ff;
   assign rd_update = rd_update_ff;
   assign ready     = !clr_busy_ff;

endmodule

FILE: src/sgdm_core.sv
// Item sequencer: read, multiply, round, saturate and write back one item.
`timescale 1ns / 1ps
module sgdm_core import sgdm_pkg::*; #(
   parameter int NUM_WEIGHTS = NUM_WEIGHTS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  req_payload_type                req_payload,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output rsp_payload_type                rsp_payload,
   input  logic [15:0]                    momentum_gain,
   input  logic [16:0]                    decrease_factor_x,
   input  logic [16:0]                    growth_scale,
   input  logic                           mem_ready,
   input  logic signed [31:0]             rd_weight,
   input  logic signed [31:0]             rd_update,
   output mem_ctl_type                    mem_ctl,
   output logic [$clog2(NUM_WEIGHTS)-1:0] rd_addr,
   output logic [$clog2(NUM_WEIGHTS)-1:0] wr_addr,
   output logic signed [31:0]             wr_weight_data,
   output logic signed [31:0]             wr_update_data
);

   localparam int AW = $clog2(NUM_WEIGHTS);

   localparam logic [1:0] ST_INIT = 2'd0;
   localparam logic [1:0] ST_IDLE = 2'd1;
   localparam logic [1:0] ST_MUL  = 2'd2;
   localparam logic [1:0] ST_WB   = 2'd3;

   logic [1:0]         state_ff;
   logic [1:0]         state_in;
   logic [1:0]         op_ff;
   logic [AW-1:0]      addr_ff;
   logic               in_range_ff;
   logic signed [31:0] value_ff;
   logic [23:0]        rate_ff;
   logic [23:0]        rate_in;
   logic signed [31:0] last_error_ff;
   logic               error_seen_ff;
   logic signed [57:0] prod_a_ff;
   logic signed [48:0] prod_b_ff;
   logic signed [32:0] mul_b;
   logic               rsp_valid_ff;
   rsp_payload_type    rsp_payload_ff;
   rsp_payload_type    rsp_in;

   logic               accept;
   logic               in_range;
   logic               out_free;
   logic               finish;
   logic signed [41:0] t1;
   logic signed [32:0] t2;
   logic signed [42:0] u_wide;
   logic signed [31:0] u_sat;
   logic               u_clip;
   logic signed [32:0] w_sum;
   logic signed [31:0] w_sat;
   logic               w_clip;
   logic [16:0]        rate_scale;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign in_range  = (32'(req_payload.index) < NUM_WEIGHTS);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign finish    = (state_ff == ST_WB) && out_free;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_INIT: if (mem_ready) state_in = ST_IDLE;
         ST_IDLE: if (accept) state_in = ST_MUL;
         ST_MUL:  state_in = ST_WB;
         ST_WB:   if (out_free) state_in = ST_IDLE;
         default: state_in = ST_INIT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff       <= req_payload.opcode;
         addr_ff     <= AW'(req_payload.index);
         in_range_ff <= in_range;
         value_ff    <= req_payload.value;
      end
   end

   // The memory read is issued on the accept edge, so data is there in ST_MUL.
   assign rd_addr = AW'(req_payload.index);

   // One multiplier is shared: rate times gradient, or rate times scale.
   always_comb begin
      rate_scale = (value_ff > last_error_ff) ? decrease_factor_x : growth_scale;
      if (op_ff == OP_REPORT) begin
         mul_b = $signed({16'd0, rate_scale});
      end else begin
         mul_b = $signed({value_ff[31], value_ff});
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_MUL) begin
         prod_a_ff <= $signed({1'b0, rate_ff}) * mul_b;
         prod_b_ff <= $signed({1'b0, momentum_gain}) * rd_update;
      end
   end

   // Rounding adds one half LSB and floors, which the arithmetic shift gives.
   always_comb begin
      t1 = 42'((prod_a_ff + 58'sd32768) >>> 16);
      t2 = 33'((prod_b_ff + 49'sd32768) >>> 16);
      u_wide = 43'(t2) - 43'(t1);
      u_clip = (u_wide[42] != u_wide[31]) || (u_wide[41:31] != {11{u_wide[42]}});
      if (!u_clip) begin
         u_sat = u_wide[31:0];
      end else if (u_wide[42]) begin
         u_sat = 32'sh80000000;
      end else begin
         u_sat = 32'sh7FFFFFFF;
      end
      w_sum  = 33'(rd_weight) + 33'(u_sat);
      w_clip = (w_sum[32] != w_sum[31]);
      if (!w_clip) begin
         w_sat = w_sum[31:0];
      end else if (w_sum[32]) begin
         w_sat = 32'sh80000000;
      end else begin
         w_sat = 32'sh7FFFFFFF;
      end
   end

   always_comb begin
      rate_in   = rate_ff;
      rsp_in    = '0;
      mem_ctl   = '0;
      mem_ctl.rd_en = accept && (req_payload.opcode == OP_GRAD) && in_range;
      case (op_ff)
         OP_LOAD: begin
            if (in_range_ff) begin
               mem_ctl.wr_weight = finish;
               rsp_in.weight     = value_ff;
            end
         end
         OP_GRAD: begin
            if (in_range_ff) begin
               mem_ctl.wr_weight = finish;
               mem_ctl.wr_update = finish;
               rsp_in.weight     = w_sat;
               rsp_in.saturated  = u_clip || w_clip;
            end
         end
         OP_REPORT: begin
            if (error_seen_ff) begin
               if (t1[41:24] != '0) begin
                  rate_in          = RATE_MAX;
                  rsp_in.saturated = 1'b1;
               end else begin
                  rate_in = t1[23:0];
               end
            end
         end
         default: ;
      endcase
      rsp_in.rate = rate_in;
   end

   assign wr_addr        = addr_ff;
   assign wr_weight_data = (op_ff == OP_LOAD) ? value_ff : w_sat;
   assign wr_update_data = u_sat;

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff       <= INITIAL_RATE_RESET;
         last_error_ff <= 32'sd0;
         error_seen_ff <= 1'b0;
      end else if (finish && (op_ff == OP_REPORT)) begin
         rate_ff       <= rate_in;
         last_error_ff <= value_ff;
         error_seen_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_payload_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

FILE: src/sgd_momentum_weight_update_top.sv
// Top level of the momentum weight update block with bold driver rate control.
`timescale 1ns / 1ps
// Usage:
// Items enter on the req_ channel (valid/stall) as load weight, apply gradient
// or report epoch error. Each item yields exactly one transaction on the rsp_
// channel carrying the new weight (zero for reports), the current rate and a
// flag that tells whether the update, the weight or the rate clipped.
// One item is in work at a time. The memory read issued at acceptance feeds
// the multiply stage, and the write back stage follows and loads the output
// register. A new item is accepted at the earliest in the cycle after the
// write back, so no new item enters before the last one has gone through
// acceptance, multiply and write back.
// A result waiting in the output register does not hold up the next item;
// only when a second result is ready and the receiver still stalls does the
// write back stage wait.
// After reset the update memory is cleared one entry per cycle; req_stall
// stays high during that pass. Configuration writes on the csr_ port are taken
// at any time. The rate restarts from its reset value at every reset.
module sgd_momentum_weight_update_top import sgdm_pkg::*; #(
   parameter int NUM_WEIGHTS = NUM_WEIGHTS_DEFAULT
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload,
   input  logic            csr_psel,
   input  logic            csr_penable,
   input  logic            csr_pwrite,
   input  logic [3:0]      csr_paddr,
   input  logic [31:0]     csr_pwdata,
   output logic [31:0]     csr_prdata,
   output logic            csr_pready
);

   localparam int AW = $clog2(NUM_WEIGHTS);

   logic [15:0]        momentum_gain;
   logic [16:0]        decrease_factor_x;
   logic [16:0]        growth_scale;
   mem_ctl_type        mem_ctl;
   logic [AW-1:0]      rd_addr;
   logic [AW-1:0]      wr_addr;
   logic signed [31:0] wr_weight_data;
   logic signed [31:0] wr_update_data;
   logic signed [31:0] rd_weight;
   logic signed [31:0] rd_update;
   logic               mem_ready;

   sgdm_csr u_csr (
      .clock             (clock),
      .reset             (reset),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready),
      .momentum_gain     (momentum_gain),
      .decrease_factor_x (decrease_factor_x),
      .growth_scale      (growth_scale)
   );

   sgdm_mem #(.NUM_WEIGHTS(NUM_WEIGHTS)) u_mem (
      .clock          (clock),
      .reset          (reset),
      .ctl            (mem_ctl),
      .rd_addr        (rd_addr),
      .wr_addr        (wr_addr),
      .wr_weight_data (wr_weight_data),
      .wr_update_data (wr_update_data),
      .rd_weight      (rd_weight),
      .rd_update      (rd_update),
      .ready          (mem_ready)
   );

   sgdm_core #(.NUM_WEIGHTS(NUM_WEIGHTS)) u_core (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_payload       (req_payload),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_payload       (rsp_payload),
      .momentum_gain     (momentum_gain),
      .decrease_factor_x (decrease_factor_x),
      .growth_scale      (growth_scale),
      .mem_ready         (mem_ready),
      .rd_weight         (rd_weight),
      .rd_update         (rd_update),
      .mem_ctl           (mem_ctl),
      .rd_addr           (rd_addr),
      .wr_addr           (wr_addr),
      .wr_weight_data    (wr_weight_data),
      .wr_update_data    (wr_update_data)
   );

endmodule

FILE: src/sgdm_checker.sv
// Port level checker of the weight update block and its bind statement.
`timescale 1ns / 1ps
`include "sgd_momentum_weight_update_top_assert.svh"
module sgdm_checker import sgdm_pkg::*; (
   input logic            clock,
   input logic            reset,
   input logic            req_valid,
   input logic            req_stall,
   input req_payload_type req_payload,
   input logic            rsp_valid,
   input logic            rsp_stall,
   input rsp_payload_type rsp_payload
);

   // A waiting result stays offered and unchanged.
   `SGDM_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid)
   `SGDM_ASSERT_NEXT(a_rsp_stable, rsp_valid && rsp_stall, $stable(rsp_payload))

   // Only one item is in work, so an accepted transaction closes the input.
   `SGDM_ASSERT_NEXT(a_one_in_work, req_valid && !req_stall, req_stall)

   // Reset empties the output register and closes the input.
   `SGDM_ASSERT_NEXT_RST(a_reset_clear, reset, !rsp_valid && req_stall)

endmodule

bind sgd_momentum_weight_update_top sgdm_checker u_checker (.*);
